// ----- hw/rtl/fss_pkg.sv -----
package fss_pkg;

	localparam int QUERY_SLOTS = 32;
	localparam int QUERY_IDX_W = 5;
	localparam int POS_W = 6;
	localparam int RUN_W = 6;
	localparam int SCORE_W = 10;
	localparam int ADD_W = 7;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int DEFAULT_MAX_QUERY_CHARS = 32;

	localparam logic [SCORE_W-1:0] SCORE_MAX = 10'd1023;
	localparam logic [SCORE_W-1:0] PREFIX_BONUS = 10'd100;
	localparam logic [ADD_W-1:0] WORD_BONUS = 7'd10;
	localparam logic [ADD_W-1:0] MATCH_BONUS = 7'd2;
	localparam logic [RUN_W-1:0] RUN_MAX = 6'd63;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_DASH = 8'h2d;
	localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	localparam logic [CFG_INDEX_W-1:0] REG_QUERY_LOW = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_QUERY_MID_LOW = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_QUERY_MID_HIGH = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_QUERY_HIGH = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_QUERY_LENGTH = 3'd4;

	typedef logic [QUERY_SLOTS-1:0][7:0] query_bytes_t;

	typedef struct packed {
		logic matched;
		logic [SCORE_W-1:0] match_score;
	} fss_result_t;

	function automatic logic [7:0] fold_char(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			r = c + CASE_OFFSET;
		end
		return r;
	endfunction

	function automatic logic is_separator(input logic [7:0] c);
		return (c == CHAR_SPACE) || (c == CHAR_DASH) || (c == CHAR_UNDERSCORE);
	endfunction

endpackage

// ----- hw/rtl/fss_if.sv -----
interface fss_name_if;
	logic valid;
	logic ready;
	logic [7:0] name_char;
	logic name_end;

	modport source(output valid, name_char, name_end, input ready);
	modport sink(input valid, name_char, name_end, output ready);
endinterface

interface fss_result_if;
	logic valid;
	logic ready;
	logic matched;
	logic [9:0] match_score;

	modport source(output valid, matched, match_score, input ready);
	modport sink(input valid, matched, match_score, output ready);
endinterface

// ----- hw/rtl/fuzzy_subsequence_scorer_top.sv -----
// Fuzzy subsequence scorer: name characters enter one per cycle, and a result item
// becomes valid on the edge at which the character that carries name_end leaves the input
// register, so the item passes through the input register and then the result register.
// Throughput is one character per cycle, set by the state update between the input
// register and the result register; the input side stalls only when a final character
// waits in the input register while an earlier result has not been taken. Load the
// query registers while no name is in flight.
module fuzzy_subsequence_scorer_top
	import fss_pkg::*;
#(
	parameter int MAX_QUERY_CHARS = DEFAULT_MAX_QUERY_CHARS
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [CFG_INDEX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	fss_name_if.sink name_in,
	fss_result_if.source result_out
);

	query_bytes_t query_bytes;
	logic [POS_W-1:0] query_len;

	logic valid_s1;
	logic [7:0] char_s1;
	logic end_s1;
	logic advance_s1;
	logic out_valid_q;
	fss_result_t res_q;
	fss_result_t res;

	fss_cfg_regs #(
		.MAX_QUERY_CHARS(MAX_QUERY_CHARS)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.query_bytes(query_bytes),
		.query_len(query_len)
	);

	assign advance_s1 = valid_s1 && (!end_s1 || !out_valid_q || result_out.ready);
	assign name_in.ready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (name_in.ready) begin
			valid_s1 <= name_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (name_in.ready && name_in.valid) begin
			char_s1 <= name_in.name_char;
			end_s1 <= name_in.name_end;
		end
	end

	fss_scorer u_scorer (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance_s1),
		.name_char(char_s1),
		.name_end(end_s1),
		.query_bytes(query_bytes),
		.query_len(query_len),
		.result(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && end_s1) begin
			res_q <= res;
		end
	end

	assign result_out.valid = out_valid_q;
	assign result_out.matched = res_q.matched;
	assign result_out.match_score = res_q.match_score;

	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && end_s1 |=> out_valid_q)
		else $error("final character advanced without producing a result");

	a_empty_stage_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> name_in.ready)
		else $error("input not ready although the input register is empty");

	a_unmatched_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && !result_out.matched |-> result_out.match_score == '0)
		else $error("unmatched result carries a nonzero score");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result_out.ready |-> !(advance_s1 && end_s1))
		else $error("pending result overwritten");

endmodule

// ----- hw/rtl/fss_cfg_regs.sv -----
module fss_cfg_regs
	import fss_pkg::*;
#(
	parameter int MAX_QUERY_CHARS = DEFAULT_MAX_QUERY_CHARS
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [CFG_INDEX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	output query_bytes_t query_bytes,
	output logic [POS_W-1:0] query_len
);

	localparam logic [POS_W-1:0] LEN_LIMIT = POS_W'(MAX_QUERY_CHARS);

	logic [CFG_DATA_W-1:0] chars_low_q;
	logic [CFG_DATA_W-1:0] chars_mid_low_q;
	logic [CFG_DATA_W-1:0] chars_mid_high_q;
	logic [CFG_DATA_W-1:0] chars_high_q;
	logic [POS_W-1:0] length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_low_q <= '0;
			chars_mid_low_q <= '0;
			chars_mid_high_q <= '0;
			chars_high_q <= '0;
			length_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_QUERY_LOW: chars_low_q <= cfg_data;
				REG_QUERY_MID_LOW: chars_mid_low_q <= cfg_data;
				REG_QUERY_MID_HIGH: chars_mid_high_q <= cfg_data;
				REG_QUERY_HIGH: chars_high_q <= cfg_data;
				REG_QUERY_LENGTH: length_q <= cfg_data[POS_W-1:0];
				default: ;
			endcase
		end
	end

	assign query_bytes = query_bytes_t'({chars_high_q, chars_mid_high_q,
		chars_mid_low_q, chars_low_q});

	// A length beyond the supported query size counts as the full size.
	assign query_len = (length_q > LEN_LIMIT) ? LEN_LIMIT : length_q;

endmodule

// ----- hw/rtl/fss_scorer.sv -----
module fss_scorer
	import fss_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic step,
	input logic [7:0] name_char,
	input logic name_end,
	input query_bytes_t query_bytes,
	input logic [POS_W-1:0] query_len,
	output fss_result_t result
);

	logic [POS_W-1:0] qpos_q;
	logic [RUN_W-1:0] run_q;
	logic word_q;
	logic [SCORE_W-1:0] score_q;
	logic [POS_W-1:0] npos_q;
	logic prefix_q;

	logic [7:0] c;
	logic npos_hit;
	logic [7:0] prefix_ch;
	logic prefix_n;
	logic [POS_W-1:0] npos_n;
	logic qpos_hit;
	logic [7:0] query_ch;
	logic qmatch;
	logic [ADD_W-1:0] add;
	logic [SCORE_W:0] sum;
	logic [SCORE_W-1:0] score_n;
	logic [RUN_W-1:0] run_n;
	logic [POS_W-1:0] qpos_n;
	logic word_n;
	logic bonus;
	logic [SCORE_W:0] final_sum;
	logic [SCORE_W-1:0] final_score;
	logic all_found;

	assign c = fold_char(name_char);

	// Prefix tracking compares the name against the query position by position.
	assign npos_hit = npos_q < query_len;
	assign prefix_ch = fold_char(query_bytes[npos_q[QUERY_IDX_W-1:0]]);
	assign prefix_n = prefix_q && !(npos_hit && prefix_ch != c);
	assign npos_n = npos_hit ? npos_q + POS_W'(1) : npos_q;

	assign qpos_hit = qpos_q < query_len;
	assign query_ch = fold_char(query_bytes[qpos_q[QUERY_IDX_W-1:0]]);
	assign qmatch = qpos_hit && (query_ch == c);

	assign add = MATCH_BONUS + ADD_W'(run_q) + (word_q ? WORD_BONUS : '0);
	assign sum = (SCORE_W+1)'(score_q) + (SCORE_W+1)'(add);
	assign score_n = !qmatch ? score_q :
		(sum > (SCORE_W+1)'(SCORE_MAX)) ? SCORE_MAX : sum[SCORE_W-1:0];

	always_comb begin
		run_n = run_q;
		if (qmatch) begin
			run_n = (run_q == RUN_MAX) ? RUN_MAX : run_q + RUN_W'(1);
		end else if (qpos_hit) begin
			run_n = '0;
		end
	end

	assign qpos_n = qmatch ? qpos_q + POS_W'(1) : qpos_q;
	assign word_n = qpos_hit ? is_separator(c) : word_q;

	assign all_found = qpos_n >= query_len;
	assign bonus = prefix_n && (npos_n >= query_len);
	assign final_sum = (SCORE_W+1)'(score_n) + (bonus ? (SCORE_W+1)'(PREFIX_BONUS) : '0);
	assign final_score = (final_sum > (SCORE_W+1)'(SCORE_MAX)) ? SCORE_MAX :
		final_sum[SCORE_W-1:0];

	assign result.matched = all_found;
	assign result.match_score = ((query_len != '0) && all_found) ? final_score : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qpos_q <= '0;
			run_q <= '0;
			word_q <= 1'b1;
			score_q <= '0;
			npos_q <= '0;
			prefix_q <= 1'b1;
		end else if (step) begin
			if (name_end) begin
				qpos_q <= '0;
				run_q <= '0;
				word_q <= 1'b1;
				score_q <= '0;
				npos_q <= '0;
				prefix_q <= 1'b1;
			end else begin
				qpos_q <= qpos_n;
				run_q <= run_n;
				word_q <= word_n;
				score_q <= score_n;
				npos_q <= npos_n;
				prefix_q <= prefix_n;
			end
		end
	end

endmodule
